@@ rtl/core/mi3_pkg.sv @@
// Shared constants and control types for the 3x3 matrix inverse pipeline.
package mi3_pkg;

  localparam int DIM      = 3;
  localparam int NUM_ELEM = DIM * DIM;

  typedef struct packed {
    logic valid;
    logic neg;
    logic singular;
  } lane_ctl_t;

endpackage

@@ rtl/core/mi3_cofactor.sv @@
// Two-stage cofactor unit: minor products, then signed cofactors.
module mi3_cofactor #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [WORD_BITS-1:0] m       [mi3_pkg::NUM_ELEM],
  output logic                        out_valid,
  output logic signed [2*WORD_BITS:0] cof     [mi3_pkg::NUM_ELEM],
  output logic signed [WORD_BITS-1:0] row0    [mi3_pkg::DIM]
);

  localparam int PW = 2 * WORD_BITS;
  localparam int CW = 2 * WORD_BITS + 1;

  logic signed [PW-1:0]        pa  [mi3_pkg::NUM_ELEM];
  logic signed [PW-1:0]        pb  [mi3_pkg::NUM_ELEM];
  logic signed [WORD_BITS-1:0] e0a [mi3_pkg::DIM];
  logic                        vld_a;

  for (genvar i = 0; i < mi3_pkg::DIM; i++) begin : g_row
    for (genvar j = 0; j < mi3_pkg::DIM; j++) begin : g_col
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;
      localparam int K  = i * mi3_pkg::DIM + j;

      always_ff @(posedge clk) begin
        pa[K] <= m[R0*mi3_pkg::DIM + C0] * m[R1*mi3_pkg::DIM + C1];
        pb[K] <= m[R0*mi3_pkg::DIM + C1] * m[R1*mi3_pkg::DIM + C0];
      end

      always_ff @(posedge clk) begin
        if (((i + j) % 2) == 1) begin
          cof[K] <= CW'(pb[K]) - CW'(pa[K]);
        end else begin
          cof[K] <= CW'(pa[K]) - CW'(pb[K]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    e0a  <= m[0:mi3_pkg::DIM-1];
    row0 <= e0a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

endmodule

@@ rtl/core/mi3_det.sv @@
// Two-stage determinant unit: split partial products, then row-0 expansion sum.
module mi3_det #(
  parameter int WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [2*WORD_BITS:0]   cof_in  [mi3_pkg::NUM_ELEM],
  input  logic signed [WORD_BITS-1:0]   row0    [mi3_pkg::DIM],
  output logic                          out_valid,
  output logic signed [2*WORD_BITS:0]   cof_out [mi3_pkg::NUM_ELEM],
  output logic signed [3*WORD_BITS+2:0] det
);

  localparam int CW = 2 * WORD_BITS + 1;
  localparam int DW = 3 * WORD_BITS + 3;

  logic signed [CW-1:0] plo   [mi3_pkg::DIM];
  logic signed [CW-1:0] phi   [mi3_pkg::DIM];
  logic signed [CW-1:0] cof_c [mi3_pkg::NUM_ELEM];
  logic signed [DW-1:0] det_next;
  logic                 vld_c;

  // cofactor = hi * 2^W + lo, lo taken as unsigned
  for (genvar j = 0; j < mi3_pkg::DIM; j++) begin : g_pp
    always_ff @(posedge clk) begin
      plo[j] <= row0[j] * $signed({1'b0, cof_in[j][WORD_BITS-1:0]});
      phi[j] <= row0[j] * $signed(cof_in[j][CW-1:WORD_BITS]);
    end
  end

  always_comb begin
    det_next = '0;
    for (int j = 0; j < mi3_pkg::DIM; j++) begin
      det_next = det_next + (DW'(phi[j]) <<< WORD_BITS) + DW'(plo[j]);
    end
  end

  always_ff @(posedge clk) begin
    cof_c   <= cof_in;
    cof_out <= cof_c;
    det     <= det_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_c     <= in_valid;
      out_valid <= vld_c;
    end
  end

endmodule

@@ rtl/core/mi3_div_lane.sv @@
// Pipelined restoring divider lane: one quotient bit per stage, then saturation.
module mi3_div_lane #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 97,
  parameter int DEN_BITS  = 99
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mi3_pkg::lane_ctl_t          in_ctl,
  input  logic [NUM_BITS-1:0]         num,
  input  logic [DEN_BITS-1:0]         den,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] res
);

  localparam int QB = WORD_BITS + 1;
  localparam int XW = (NUM_BITS > DEN_BITS + QB) ? NUM_BITS : DEN_BITS + QB;

  mi3_pkg::lane_ctl_t  ctl [QB+1];
  logic [XW-1:0]       rem [QB+1];
  logic [DEN_BITS-1:0] dv  [QB+1];
  logic [QB-1:0]       quo [QB+1];
  logic                ovf [QB+1];
  logic                big;

  // quotient too wide for the stages below: flag and saturate
  always_ff @(posedge clk) begin
    rem[0] <= XW'(num);
    dv[0]  <= den;
    quo[0] <= '0;
    ovf[0] <= (XW'(num) >= (XW'(den) << QB));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= in_ctl.valid;
    end
    ctl[0].neg      <= in_ctl.neg;
    ctl[0].singular <= in_ctl.singular;
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int B = QB - 1 - g;
    logic [XW-1:0] sh;
    logic          ge;

    assign sh = XW'(dv[g]) << B;
    assign ge = (rem[g] >= sh);

    always_ff @(posedge clk) begin
      rem[g+1] <= ge ? (rem[g] - sh) : rem[g];
      dv[g+1]  <= dv[g];
      ovf[g+1] <= ovf[g];
      quo[g+1] <= quo[g] | (QB'(ge) << B);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[g+1].valid <= 1'b0;
      end else begin
        ctl[g+1].valid <= ctl[g].valid;
      end
      ctl[g+1].neg      <= ctl[g].neg;
      ctl[g+1].singular <= ctl[g].singular;
    end
  end

  assign big = ovf[QB] | quo[QB][QB-1] | quo[QB][QB-2];

  always_ff @(posedge clk) begin
    if (ctl[QB].singular) begin
      res <= '0;
    end else if (ctl[QB].neg) begin
      res <= big ? {1'b1, {(WORD_BITS-1){1'b0}}} : -$signed(quo[QB][WORD_BITS-1:0]);
    end else begin
      res <= big ? {1'b0, {(WORD_BITS-1){1'b1}}} : $signed(quo[QB][WORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[QB].valid;
    end
  end

endmodule

@@ rtl/core/matrix3x3_inverse.sv @@
// Throughput: one request per cycle; busy stays low, as the pipeline never stalls.
// The divider lanes resolve one quotient bit per stage.
// Each result shows for one cycle with done; the receiver cannot hold it off.
// Reset (synchronous, rst high) clears all valid bits; data registers are not reset.
module matrix3x3_inverse #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] m00,
  input  logic signed [WORD_BITS-1:0] m01,
  input  logic signed [WORD_BITS-1:0] m02,
  input  logic signed [WORD_BITS-1:0] m10,
  input  logic signed [WORD_BITS-1:0] m11,
  input  logic signed [WORD_BITS-1:0] m12,
  input  logic signed [WORD_BITS-1:0] m20,
  input  logic signed [WORD_BITS-1:0] m21,
  input  logic signed [WORD_BITS-1:0] m22,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] r00,
  output logic signed [WORD_BITS-1:0] r01,
  output logic signed [WORD_BITS-1:0] r02,
  output logic signed [WORD_BITS-1:0] r10,
  output logic signed [WORD_BITS-1:0] r11,
  output logic signed [WORD_BITS-1:0] r12,
  output logic signed [WORD_BITS-1:0] r20,
  output logic signed [WORD_BITS-1:0] r21,
  output logic signed [WORD_BITS-1:0] r22,
  output logic signed [WORD_BITS-1:0] det_value,
  output logic                        singular
);

  localparam int CW  = 2 * WORD_BITS + 1;
  localparam int DW  = 3 * WORD_BITS + 3;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int QB  = WORD_BITS + 1;
  localparam int DL  = QB + 3;
  localparam int LAT = WORD_BITS + 8;

  logic signed [WORD_BITS-1:0] m_in  [mi3_pkg::NUM_ELEM];
  logic signed [WORD_BITS-1:0] res   [mi3_pkg::NUM_ELEM];
  logic signed [CW-1:0]        cof_b [mi3_pkg::NUM_ELEM];
  logic signed [CW-1:0]        cof_d [mi3_pkg::NUM_ELEM];
  logic signed [WORD_BITS-1:0] row0  [mi3_pkg::DIM];
  logic signed [DW-1:0]        det_d;
  logic                        vld_b;
  logic                        vld_d;

  logic [NW-1:0]               num_e  [mi3_pkg::NUM_ELEM];
  logic                        cneg_e [mi3_pkg::NUM_ELEM];
  logic [DW-1:0]               dmag_e;
  logic                        dneg_e;
  logic                        sing_e;
  logic                        vld_e;
  logic [DW-1:0]               dmag;
  logic [DW-1:0]               dshr;
  logic                        dbig;
  logic signed [WORD_BITS-1:0] dsat;

  logic signed [WORD_BITS-1:0] dly_det  [DL];
  logic                        dly_sing [DL];
  logic [mi3_pkg::NUM_ELEM-1:0] lane_vld;

  assign busy = 1'b0;

  assign m_in[0] = m00;
  assign m_in[1] = m01;
  assign m_in[2] = m02;
  assign m_in[3] = m10;
  assign m_in[4] = m11;
  assign m_in[5] = m12;
  assign m_in[6] = m20;
  assign m_in[7] = m21;
  assign m_in[8] = m22;

  mi3_cofactor #(
    .WORD_BITS(WORD_BITS)
  ) u_cof (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .m        (m_in),
    .out_valid(vld_b),
    .cof      (cof_b),
    .row0     (row0)
  );

  mi3_det #(
    .WORD_BITS(WORD_BITS)
  ) u_det (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld_b),
    .cof_in   (cof_b),
    .row0     (row0),
    .out_valid(vld_d),
    .cof_out  (cof_d),
    .det      (det_d)
  );

  // sign and magnitude of determinant and cofactors
  assign dmag = det_d[DW-1] ? DW'(-det_d) : DW'(det_d);
  assign dshr = dmag >> (2 * FRAC_BITS);
  assign dbig = |dshr[DW-1:WORD_BITS-1];

  always_comb begin
    if (det_d == '0) begin
      dsat = '0;
    end else if (det_d[DW-1]) begin
      dsat = dbig ? {1'b1, {(WORD_BITS-1){1'b0}}} : -$signed(dshr[WORD_BITS-1:0]);
    end else begin
      dsat = dbig ? {1'b0, {(WORD_BITS-1){1'b1}}} : $signed(dshr[WORD_BITS-1:0]);
    end
  end

  for (genvar k = 0; k < mi3_pkg::NUM_ELEM; k++) begin : g_mag
    always_ff @(posedge clk) begin
      num_e[k]  <= NW'(cof_d[k][CW-1] ? CW'(-cof_d[k]) : CW'(cof_d[k])) << (2 * FRAC_BITS);
      cneg_e[k] <= cof_d[k][CW-1];
    end
  end

  always_ff @(posedge clk) begin
    dmag_e     <= dmag;
    dneg_e     <= det_d[DW-1];
    sing_e     <= (det_d == '0);
    dly_det[0]  <= dsat;
    dly_sing[0] <= (det_d == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
    end else begin
      vld_e <= vld_d;
    end
  end

  // hold determinant and flag in step with the divider lanes
  for (genvar t = 1; t < DL; t++) begin : g_dly
    always_ff @(posedge clk) begin
      dly_det[t]  <= dly_det[t-1];
      dly_sing[t] <= dly_sing[t-1];
    end
  end

  // output (a,b) takes cofactor (b,a)
  for (genvar a = 0; a < mi3_pkg::DIM; a++) begin : g_lr
    for (genvar b = 0; b < mi3_pkg::DIM; b++) begin : g_lc
      localparam int O = a * mi3_pkg::DIM + b;
      localparam int C = b * mi3_pkg::DIM + a;
      mi3_pkg::lane_ctl_t ctl;

      assign ctl.valid    = vld_e;
      assign ctl.neg      = cneg_e[C] ^ dneg_e;
      assign ctl.singular = sing_e;

      mi3_div_lane #(
        .WORD_BITS(WORD_BITS),
        .NUM_BITS (NW),
        .DEN_BITS (DW)
      ) u_lane (
        .clk      (clk),
        .rst      (rst),
        .in_ctl   (ctl),
        .num      (num_e[C]),
        .den      (dmag_e),
        .out_valid(lane_vld[O]),
        .res      (res[O])
      );
    end
  end

  assign done      = lane_vld[0];
  assign r00       = res[0];
  assign r01       = res[1];
  assign r02       = res[2];
  assign r10       = res[3];
  assign r11       = res[4];
  assign r12       = res[5];
  assign r20       = res[6];
  assign r21       = res[7];
  assign r22       = res[8];
  assign det_value = dly_det[DL-1];
  assign singular  = dly_sing[DL-1];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not produce a result strobe on time");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    done == (&lane_vld))
    else $error("divider lanes out of step");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (det_value == '0 && r00 == '0 && r11 == '0 && r22 == '0))
    else $error("singular result carries nonzero data");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

@@ sim/matrix3x3_inverse_tb.sv @@
// Testbench for matrix3x3_inverse: directed and random matrices checked against a built-in predictor.
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1830;
  localparam int SETTLE_CYCLES = WB + 20;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    word_t m [mi3_pkg::NUM_ELEM];
  } matrix_t;

  typedef struct {
    word_t r [mi3_pkg::NUM_ELEM];
    word_t det;
    logic  sing;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  word_t mi [mi3_pkg::NUM_ELEM];
  logic done;
  word_t ro [mi3_pkg::NUM_ELEM];
  word_t det_value;
  logic singular;

  matrix_t  pending_q [$];
  inverse_t inverse_q [$];
  int n_sent = 0;
  int n_checked = 0;
  int n_singular = 0;
  int n_errors = 0;
  int stall_cnt = 0;
  bit stim_done = 1'b0;

  always #4 clk = ~clk;

  matrix3x3_inverse u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(mi[0]), .m01(mi[1]), .m02(mi[2]),
    .m10(mi[3]), .m11(mi[4]), .m12(mi[5]),
    .m20(mi[6]), .m21(mi[7]), .m22(mi[8]),
    .done(done),
    .r00(ro[0]), .r01(ro[1]), .r02(ro[2]),
    .r10(ro[3]), .r11(ro[4]), .r12(ro[5]),
    .r20(ro[6]), .r21(ro[7]), .r22(ro[8]),
    .det_value(det_value), .singular(singular)
  );

  function automatic word_t saturate_word(logic neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = 128'd1 << (WB - 1);
    if (neg) begin
      if (mag >= lim) return word_t'(lim);
      return word_t'(-mag);
    end
    if (mag > lim - 1) return word_t'(lim - 1);
    return word_t'(mag);
  endfunction

  function automatic inverse_t invert_matrix(matrix_t a);
    inverse_t res;
    wide_t e [3][3];
    wide_t cof [3][3];
    wide_t mn, det;
    logic [127:0] dmag, num;
    logic dneg, cneg;
    int r0, r1, c0, c1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = wide_t'(a.m[i*3+j]);
    for (int i = 0; i < 3; i++) begin
      r0 = (i == 0) ? 1 : 0;
      r1 = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        mn = e[r0][c0] * e[r1][c1] - e[r0][c1] * e[r1][c0];
        cof[i][j] = ((i + j) % 2 == 1) ? -mn : mn;
      end
    end
    det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
    if (det == 0) begin
      foreach (res.r[k]) res.r[k] = '0;
      res.det = '0;
      res.sing = 1'b1;
      return res;
    end
    dneg = det[127];
    dmag = dneg ? -det : det;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        cneg = cof[i][j][127];
        num = (cneg ? -cof[i][j] : cof[i][j]);
        num = num << (2 * FB);
        res.r[j*3+i] = saturate_word(cneg != dneg, num / dmag);
      end
    res.det = saturate_word(dneg, dmag >> (2 * FB));
    res.sing = 1'b0;
    return res;
  endfunction

  // Element drawn from a few magnitude classes so inverses stay in range often.
  function automatic word_t rand_elem(int cls);
    case (cls)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
      2: return word_t'($urandom_range(0, 32'h0000_0200)) - word_t'(32'h0000_0100);
      default: return ($urandom_range(0, 1) == 1) ? word_t'(32'h7FFF_FFFF)
                                                   : word_t'(32'h8000_0000);
    endcase
  endfunction

  task automatic add_matrix(word_t a0, word_t a1, word_t a2, word_t a3, word_t a4,
                            word_t a5, word_t a6, word_t a7, word_t a8);
    matrix_t t;
    t.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    pending_q.push_back(t);
  endtask

  // Driver: hand a request to the block, then pick the next one or idle.
  always @(posedge clk) begin
    int idle_pct;
    matrix_t nxt;
    if (rst) begin
      start <= 1'b0;
      foreach (mi[k]) mi[k] <= '0;
    end else begin
      if (start && !busy) begin
        inverse_q.push_back(invert_matrix(pending_q.pop_front()));
        n_sent++;
      end
      if (start && busy) begin
        // hold the request until accepted
      end else begin
        idle_pct = (n_sent < 620) ? 33 : (n_sent < 1240) ? 50 : 0;
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = pending_q[0];
          foreach (mi[k]) mi[k] <= nxt.m[k];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    inverse_t exp_r;
    if (!rst && done) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result, det_value=%h", $time, det_value);
        n_errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        n_checked++;
        if (exp_r.sing) n_singular++;
        foreach (ro[k])
          if (ro[k] !== exp_r.r[k]) begin
            $display("%0t: r%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     exp_r.r[k], ro[k]);
            n_errors++;
          end
        if (det_value !== exp_r.det) begin
          $display("%0t: det_value expected %h actual %h", $time, exp_r.det, det_value);
          n_errors++;
        end
        if (singular !== exp_r.sing) begin
          $display("%0t: singular expected %b actual %b", $time, exp_r.sing, singular);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake of either kind.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || stim_done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, inverse_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    word_t one, lsb, mx, mn;
    int cls;
    matrix_t t;
    one = 32'h0001_0000;
    lsb = 32'h0000_0001;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    add_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_matrix(one, 0, 0, 0, one, 0, 0, 0, one);
    add_matrix(-one, 0, 0, 0, -one, 0, 0, 0, -one);
    add_matrix(0, one, 0, one, 0, 0, 0, 0, one);
    add_matrix(2*one, 0, 0, 0, 4*one, 0, 0, 0, -8*one);
    add_matrix(lsb, 0, 0, 0, lsb, 0, 0, 0, lsb);
    add_matrix(-lsb, 0, 0, 0, lsb, 0, 0, 0, lsb);
    add_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx);
    add_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn);
    add_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_matrix(mn, mx, mn, mx, mn, mx, mn, mx, mn);
    add_matrix(mn, 0, 0, 0, mx, 0, 0, 0, mn);
    add_matrix(one, 2*one, 3*one, one, 2*one, 3*one, 4*one, 5*one, 6*one);
    add_matrix(one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one);
    add_matrix(2*one, one, one, one, 3*one, 2*one, one, 0, 0);
    add_matrix(lsb, lsb, 0, 0, lsb, lsb, lsb, 0, lsb);
    add_matrix(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
               32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC, 32'h0000_FFFF,
               32'hFFFF_0000);
    for (int n = 0; n < N_RANDOM; n++) begin
      cls = $urandom_range(0, 9);
      cls = (cls < 4) ? 0 : (cls < 7) ? 1 : (cls < 9) ? 2 : 3;
      foreach (t.m[k]) t.m[k] = rand_elem((cls == 3 && $urandom_range(0, 1) == 1)
                                          ? 0 : cls);
      // make some matrices singular by repeating a row, repeating one negated, or zeroing a row
      case ($urandom_range(0, 15))
        0: for (int c = 0; c < 3; c++) t.m[3+c] = t.m[c];
        1: for (int c = 0; c < 3; c++) t.m[6+c] = -t.m[3+c];
        2: for (int c = 0; c < 3; c++) t.m[c] = '0;
        default: ;
      endcase
      pending_q.push_back(t);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || inverse_q.size() != 0) @(posedge clk);
    stim_done = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Inverted %0d matrices (%0d singular), full-range, scaled and saturating cases.",
             n_checked, n_singular);
    $display("Sender ran with 33%% and 50%% idle cycles, then back to back.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ matrix3x3_inverse.f @@
rtl/core/mi3_pkg.sv
rtl/core/mi3_cofactor.sv
rtl/core/mi3_det.sv
rtl/core/mi3_div_lane.sv
rtl/core/matrix3x3_inverse.sv
sim/matrix3x3_inverse_tb.sv
